// ===== sv/prt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prt_pkg: shared types for the pending reply table
// commands, table entry, per-cell control and the packed result
// ----------------------------------------------------------------------------
package prt_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_ACK    = 2'd2,
    CMD_TICK   = 2'd3
  } prt_cmd_e;

  typedef struct packed {
    logic [15:0] msg_type;
    logic [15:0] app_id;
    logic [31:0] remaining;
    logic [7:0]  tag;
  } prt_entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic load;    // append the new entry at the first free cell
    logic tick;    // age every entry, drop the ones that run out
    logic search;  // capture the match flag against the new entry key
    logic clear;   // drop the selected cell
  } prt_ctrl_t;

  typedef struct packed {
    logic [4:0] expired_count;
    logic       wake;
    logic [7:0] found_tag;
    logic       ok;
  } prt_result_t;

  localparam int unsigned ResultW = $bits(prt_result_t);
  localparam int unsigned ExpSat  = 31;

endpackage
`default_nettype wire

// ===== sv/prt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prt_cell: one slot of the pending reply table
// holds one entry, compares and ages it, and pulls from its upper neighbor
// whenever the slot is empty, so holes bubble to the young end
// ----------------------------------------------------------------------------
module prt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prt_pkg::prt_ctrl_t  ctrl_i,
  input  prt_pkg::prt_entry_t item_i,
  input  logic [15:0]         interval_i,
  input  logic                sel_i,
  input  logic                prev_valid_i,
  input  logic                next_valid_i,
  input  prt_pkg::prt_entry_t next_entry_i,
  output logic                valid_o,
  output prt_pkg::prt_entry_t entry_o,
  output logic                match_o
);
  import prt_pkg::*;

  logic       valid_q, valid_d;
  logic       match_q, match_d;
  prt_entry_t entry_q, entry_d;
  logic       pull, give, expire;
  logic [31:0] interval_ext;

  assign interval_ext = {16'd0, interval_i};
  assign expire       = entry_q.remaining <= interval_ext;
  // empty slot takes the neighbor above; a slot over a hole hands itself down
  assign pull         = !valid_q && next_valid_i;
  assign give         = valid_q && !prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.load && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      entry_d = item_i;
    end else if (ctrl_i.tick && valid_q) begin
      if (expire) begin
        valid_d = 1'b0;
      end else begin
        entry_d.remaining = entry_q.remaining - interval_ext;
      end
    end else if (ctrl_i.clear && sel_i) begin
      valid_d = 1'b0;
    end else if (pull) begin
      valid_d = 1'b1;
      entry_d = next_entry_i;
    end else if (give) begin
      valid_d = 1'b0;
    end
  end

  always_comb begin
    match_d = match_q;
    if (ctrl_i.search) begin
      match_d = valid_q && (entry_q.msg_type == item_i.msg_type)
                && (entry_q.app_id == item_i.app_id);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule
`default_nettype wire

// ===== sv/pending_reply_table_with_timeout.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pending_reply_table_with_timeout: insertion-ordered table of awaited replies
// a row of slot cells with insert, oldest-match lookup, acknowledge and
// timeout aging; removals are closed up by a neighbor-to-neighbor shift
// ----------------------------------------------------------------------------
//
//  channel  | dir | tvalid/tready                     | tdata / tuser
//  ---------+-----+-----------------------------------+------------------------------
//  command  | in  | s_axis_tvalid_i / s_axis_tready_o | tuser: cmd; tdata: see port
//  result   | out | m_axis_tvalid_o / m_axis_tready_i | tdata: see port
//
//  insert writes its result straight from the idle state; lookup and acknowledge
//  pass through the match state (match flags are registered in the cells, then
//  the oldest match is picked); an acknowledge with a match and a tick then
//  wait in the compact state: holes move one slot per cycle through the cell
//  row until the table is packed again
//  a new command is taken only when the table is packed and the result
//  register is free or being drained; the result register holds under stall
//  reset clears every slot valid bit and the result valid flag at once
//
module pending_reply_table_with_timeout #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // msg_type[15:0], app_id[31:16], timeout[63:32], handler_tag[71:64],
  // quiet[72], tick_interval[88:73], zero pad[95:89]
  input  logic [95:0] s_axis_tdata_i,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // ok[0], found_tag[8:1], wake[9], expired_count[14:10], zero pad[15]
  output logic [15:0] m_axis_tdata_o
);
  import prt_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW   = (CntW > 5) ? CntW : 5;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_MATCH   = 3'b010,
    ST_COMPACT = 3'b100
  } state_e;

  state_e      state_q, state_d;
  prt_cmd_e    cmd_q, cmd_d, cmd_in;
  logic        quiet_q, quiet_d;
  logic [CntW-1:0] before_q, before_d;
  logic        m_valid_q, m_valid_d;
  prt_result_t res_q, res_d;

  prt_entry_t  item;
  logic        quiet_in;
  logic [15:0] interval_in;
  logic        accept;
  prt_ctrl_t   ctrl;

  // cell row wiring; index TABLE_DEPTH is the empty slot above the top cell
  logic [TABLE_DEPTH:0]   valid_w;
  prt_entry_t             entry_w [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] match_w;
  logic [TABLE_DEPTH-1:0] first_w;
  logic [TABLE_DEPTH-1:0] prev_w;

  logic            hole;
  logic            found;
  logic [7:0]      sel_tag;
  logic [CntW-1:0] fill;
  logic [XW-1:0]   expired;

  // unpack the command transfer
  assign cmd_in         = prt_cmd_e'(s_axis_tuser_i);
  assign item.msg_type  = s_axis_tdata_i[15:0];
  assign item.app_id    = s_axis_tdata_i[31:16];
  assign item.remaining = s_axis_tdata_i[63:32];
  assign item.tag       = s_axis_tdata_i[71:64];
  assign quiet_in       = s_axis_tdata_i[72];
  assign interval_in    = s_axis_tdata_i[88:73];

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // one-hot select of the oldest match is the lowest set match bit
  assign first_w = match_w & (~match_w + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
  assign found   = |match_w;

  always_comb begin
    ctrl.load   = accept && (cmd_in == CMD_INSERT);
    ctrl.tick   = accept && (cmd_in == CMD_TICK);
    ctrl.search = accept && ((cmd_in == CMD_LOOKUP) || (cmd_in == CMD_ACK));
    ctrl.clear  = (state_q == ST_MATCH) && (cmd_q == CMD_ACK) && found;
  end

  assign valid_w[TABLE_DEPTH] = 1'b0;
  assign entry_w[TABLE_DEPTH] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_w[g] = 1'b1;
    end else begin : g_body
      assign prev_w[g] = valid_w[g-1];
    end

    prt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .item_i       (item),
      .interval_i   (interval_in),
      .sel_i        (first_w[g]),
      .prev_valid_i (prev_w[g]),
      .next_valid_i (valid_w[g+1]),
      .next_entry_i (entry_w[g+1]),
      .valid_o      (valid_w[g]),
      .entry_o      (entry_w[g]),
      .match_o      (match_w[g])
    );
  end

  // tag of the oldest match, one-hot and-or over the row
  always_comb begin
    sel_tag = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_tag = sel_tag | (entry_w[i].tag & {8{first_w[i]}});
    end
  end

  // an empty slot below a full one means the row is not packed yet
  always_comb begin
    hole = 1'b0;
    for (int i = 0; i + 1 < TABLE_DEPTH; i++) begin
      hole = hole | (!valid_w[i] && valid_w[i+1]);
    end
  end

  // fill level of a packed row: thermometer to count
  always_comb begin
    fill = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (valid_w[i]) begin
        fill = CntW'(i + 1);
      end
    end
  end

  assign expired = XW'(before_q - fill);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    quiet_d   = quiet_q;
    before_d  = before_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    res_d     = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d    = cmd_in;
          quiet_d  = quiet_in;
          before_d = fill;
          case (cmd_in)
            CMD_INSERT: begin
              m_valid_d = 1'b1;
              res_d     = '0;
              res_d.ok  = !valid_w[TABLE_DEPTH-1];
            end
            CMD_TICK: state_d = ST_COMPACT;
            default:  state_d = ST_MATCH;
          endcase
        end
      end
      ST_MATCH: begin
        // result register was freed when this command was taken
        m_valid_d       = 1'b1;
        res_d           = '0;
        res_d.ok        = found;
        res_d.found_tag = found ? sel_tag : 8'd0;
        res_d.wake      = found && (cmd_q == CMD_ACK) && !quiet_q;
        state_d         = (found && (cmd_q == CMD_ACK)) ? ST_COMPACT : ST_IDLE;
      end
      ST_COMPACT: begin
        if (!hole) begin
          state_d = ST_IDLE;
          if (cmd_q == CMD_TICK) begin
            m_valid_d           = 1'b1;
            res_d               = '0;
            res_d.expired_count = (expired > XW'(ExpSat)) ? 5'(ExpSat) : expired[4:0];
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    quiet_q  <= quiet_d;
    before_q <= before_d;
    res_q    <= res_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(16 - ResultW){1'b0}}, res_q};

`ifndef ASSERT_OFF
  // commands are only taken with the row packed
  a_packed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !hole)
    else $error("slot row has a hole while idle");

  // at most one slot is picked for removal
  a_single_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MATCH) |-> $onehot0(first_w))
    else $error("more than one oldest match");

  // the match result never overwrites a pending result
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MATCH) |-> !m_valid_q)
    else $error("result register busy when match result is due");

  // a tick never grows the table
  a_tick_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_COMPACT) && !hole && (cmd_q == CMD_TICK)) |-> (fill <= before_q))
    else $error("fill level grew across a tick");
`endif

endmodule
`default_nettype wire
